### rtl/core/utt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_pkg
// Shared beat types, decode state, result bundle and byte class helpers for
// the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

	// Most code units one input byte can produce
	localparam int MAX_UNITS = 4;
	// Held bytes of a partial sequence
	localparam int HOLD_DEPTH = 3;

	// Byte class masks and patterns
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_VAL   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;

	// Sequence lengths a lead byte asks for
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	// Surrogate bases and supplementary plane start
	localparam logic [15:0] SURR_HI   = 16'hD800;
	localparam logic [15:0] SURR_LO   = 16'hDC00;
	localparam logic [19:0] SUPP_BASE = 20'h10000;

	// Input beat
	typedef struct packed {
		logic [7:0] input_byte;
		logic       last_byte;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [15:0] code_unit;
		logic        run_last;
		logic        text_done;
		logic [15:0] unit_count;
	} out_beat_t;

	// Units produced by one byte, handed from decoder to output buffer
	typedef struct packed {
		logic [MAX_UNITS-1:0][15:0] units;
		logic [2:0]                 n;
		logic [15:0]                first_count;
		logic                       last;
	} res_t;

	// Decoder state
	typedef struct packed {
		logic [HOLD_DEPTH-1:0][7:0] pb;
		logic [1:0]                 pcnt;
		logic [2:0]                 slen;
		logic [15:0]                units_emitted;
	} dec_state_t;

	// Length of the sequence a byte opens, SEQ_NONE when it opens none
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = SEQ_NONE;
		if ((b & LEAD2_MASK) == LEAD2_VAL)
			len = SEQ_LEN2;
		else if ((b & LEAD3_MASK) == LEAD3_VAL)
			len = SEQ_LEN3;
		else if ((b & LEAD4_MASK) == LEAD4_VAL)
			len = SEQ_LEN4;
		return len;
	endfunction

	// Append one unit to a result bundle, dropping anything past the limit
	function automatic res_t push_unit(input res_t r, input logic [15:0] u);
		res_t t;
		t = r;
		if (t.n < 3'(MAX_UNITS)) begin
			t.units[t.n[1:0]] = u;
			t.n = t.n + 3'd1;
		end
		return t;
	endfunction

endpackage

### rtl/core/utt_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_in_stage
// Input register: captures one byte beat and holds it until the decoder
// takes it.
// ----------------------------------------------------------------------------
module utt_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  utt_pkg::in_beat_t  in_data,
	input  logic               advance,
	output logic               valid_s1,
	output utt_pkg::in_beat_t  data_s1
);

	// Accept whenever the slot is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

### rtl/core/utt_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_decode
// Sequence tracker: holds a partial UTF-8 sequence and turns each byte into
// zero to four UTF-16 units in a single pass.
// ----------------------------------------------------------------------------
module utt_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  utt_pkg::in_beat_t  data_s1,
	output utt_pkg::res_t      res
);

	utt_pkg::dec_state_t st_q;
	utt_pkg::dec_state_t st_d;

	logic [7:0]  b;
	logic        cont;
	logic        fresh;
	logic [2:0]  len;
	logic [5:0]  c;
	logic [20:0] cp;
	logic [19:0] off;

	assign b    = data_s1.input_byte;
	assign cont = (b & utt_pkg::CONT_MASK) == utt_pkg::CONT_VAL;
	assign len  = utt_pkg::lead_len(b);
	assign c    = b[5:0];

	// Nothing usable held: start over at this byte
	assign fresh = (st_q.pcnt == 2'd0) || (st_q.slen < utt_pkg::SEQ_LEN2) ||
		(st_q.slen > utt_pkg::SEQ_LEN4) || ({1'b0, st_q.pcnt} >= st_q.slen);

	// Assemble the code point from the held bytes and this continuation
	always_comb begin
		case (st_q.slen)
			utt_pkg::SEQ_LEN2: cp = {10'd0, st_q.pb[0][4:0], c};
			utt_pkg::SEQ_LEN3: cp = {5'd0, st_q.pb[0][3:0], st_q.pb[1][5:0], c};
			default: cp = {st_q.pb[0][2:0], st_q.pb[1][5:0], st_q.pb[2][5:0], c};
		endcase
	end

	assign off = cp[19:0] - utt_pkg::SUPP_BASE;

	// Build the unit list and the next state
	always_comb begin
		utt_pkg::res_t r;
		utt_pkg::dec_state_t s;
		r = '0;
		s = st_q;
		r.first_count = st_q.units_emitted + 16'd1;
		r.last = data_s1.last_byte;

		// Broken sequence or stale hold: drop held bytes out raw
		if (st_q.pcnt != 2'd0 && (fresh || !cont)) begin
			for (int i = 0; i < utt_pkg::HOLD_DEPTH; i++) begin
				if (2'(i) < st_q.pcnt)
					r = utt_pkg::push_unit(r, {8'h00, st_q.pb[i]});
			end
			s.pcnt = 2'd0;
			s.slen = utt_pkg::SEQ_NONE;
		end

		if (fresh || !cont) begin
			// Open a sequence or pass the byte through
			if (len == utt_pkg::SEQ_NONE) begin
				r = utt_pkg::push_unit(r, {8'h00, b});
			end else begin
				s.pb[0] = b;
				s.pcnt = 2'd1;
				s.slen = len;
			end
		end else if ({1'b0, st_q.pcnt} + 3'd1 == st_q.slen) begin
			// Sequence complete: one unit or a surrogate pair
			if (cp[20:16] != 5'd0) begin
				r = utt_pkg::push_unit(r, utt_pkg::SURR_HI + {6'd0, off[19:10]});
				r = utt_pkg::push_unit(r, utt_pkg::SURR_LO + {6'd0, off[9:0]});
			end else begin
				r = utt_pkg::push_unit(r, cp[15:0]);
			end
			s.pcnt = 2'd0;
			s.slen = utt_pkg::SEQ_NONE;
		end else begin
			// Hold the continuation byte
			if (st_q.pcnt != 2'd3)
				s.pb[st_q.pcnt] = b;
			s.pcnt = st_q.pcnt + 2'd1;
		end

		// End of text: flush what is still held and start the count over
		if (data_s1.last_byte) begin
			for (int i = 0; i < utt_pkg::HOLD_DEPTH; i++) begin
				if (2'(i) < s.pcnt)
					r = utt_pkg::push_unit(r, {8'h00, s.pb[i]});
			end
			s.pcnt = 2'd0;
			s.slen = utt_pkg::SEQ_NONE;
			s.pb = '0;
			s.units_emitted = 16'd0;
		end else begin
			s.units_emitted = st_q.units_emitted + {13'd0, r.n};
		end

		res = r;
		st_d = s;
	end

	// Advance state when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

endmodule

### rtl/core/utt_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_out_buf
// Result register: holds the units of one byte and sends them one beat at
// a time, with position flags and the running unit count.
// ----------------------------------------------------------------------------
module utt_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  utt_pkg::res_t      res,
	output logic               buf_free,
	output logic               out_valid,
	input  logic               out_ready,
	output utt_pkg::out_beat_t out_data
);

	logic [utt_pkg::MAX_UNITS-1:0][15:0] units_q;
	logic [2:0]  rem_q;
	logic [1:0]  rd_q;
	logic [15:0] count_q;
	logic        last_q;
	logic        pop;

	assign out_valid = rem_q != 3'd0;
	assign pop       = out_valid && out_ready;
	// Room for a new set once the last held beat goes out
	assign buf_free  = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready);

	// Drive the current beat
	always_comb begin
		out_data.code_unit  = units_q[rd_q];
		out_data.run_last   = rem_q == 3'd1;
		out_data.text_done  = (rem_q == 3'd1) && last_q;
		out_data.unit_count = count_q;
	end

	// Track remaining beats and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (load && res.n != 3'd0) begin
			rem_q <= res.n;
			rd_q  <= 2'd0;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// Hold payload and advance the unit count
	always_ff @(posedge clk) begin
		if (load && res.n != 3'd0) begin
			units_q <= res.units;
			count_q <= res.first_count;
			last_q  <= res.last;
		end else if (pop) begin
			count_q <= count_q + 16'd1;
		end
	end

endmodule

### rtl/core/utf8_to_utf16_transcoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one text byte per beat with
// last_byte set on the final byte of a text. Output channel
// out_valid/out_ready/out_data carries one code unit per beat with run_last
// on the last unit caused by a byte, text_done on the final unit of a text,
// and unit_count counting units within the text (wraps at 16 bits).
// A byte moves from the input register to the result register. Throughput:
// one byte per cycle while each byte yields at most one unit and out_ready
// holds; a byte with k units holds the result register until all k leave
// (surrogate pairs, broken sequences, end-of-text flush; up to 4). The
// single-entry result register drains one unit per cycle while out_ready
// holds. Bytes that only extend a held sequence yield no beat.
// Reset clears the held sequence, the unit count and both valid flags.
// When the receiver stalls, the current beat holds, the input register
// fills and in_ready drops until the result register frees up.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  utt_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output utt_pkg::out_beat_t out_data
);

	logic              valid_s1;
	utt_pkg::in_beat_t data_s1;
	logic              buf_free;
	logic              advance;
	utt_pkg::res_t     res;

	// Move a byte from input register into the result register
	assign advance = valid_s1 && buf_free;

	utt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	utt_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data_s1 (data_s1),
		.res     (res)
	);

	utt_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.buf_free  (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### rtl/core/utt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utt_checker
// Port-level checks on the transcoder output channel.
// ----------------------------------------------------------------------------
module utt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input utt_pkg::out_beat_t out_data
);

	// Stalled beat stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// Stalled beat keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// End of text only on the closing unit of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.text_done |-> out_data.run_last)
		else $error("text_done without run_last");

	// Units of one byte leave without gaps, counting up by one
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.run_last |=>
			out_valid && out_data.unit_count == $past(out_data.unit_count) + 16'd1)
		else $error("gap or count skip inside one byte's units");

endmodule

bind utf8_to_utf16_transcoder_top utt_checker u_utt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
